>>> rtl/core/rrd_pkg.sv
// Package for the response deframer: queue entry type, operation and status codes,
// phase encoding and the CRC-16 byte update function.
// Used by every module under rtl/core; no dependencies of its own.
package rrd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FUNC_MASK      = 8'hF0;
   localparam logic [7:0] FUNC_EXCEPTION = 8'h80;
   localparam logic [7:0] FUNC_COILS     = 8'h05;
   localparam logic [7:0] FUNC_INPUTS    = 8'h02;
   localparam logic [7:0] FUNC_HOLDING   = 8'h03;

   localparam logic [8:0] LEN_EXCEPTION = 9'd5;
   localparam logic [8:0] LEN_COILS     = 9'd8;
   localparam logic [8:0] LEN_INPUTS    = 9'd7;
   localparam logic [8:0] LEN_OVERHEAD  = 9'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_FUNC,
      PH_COUNT,
      PH_BODY
   } phase_type;

   // What the back end does with a queued byte.
   typedef enum logic [2:0] {
      OP_START,   // address byte: restart CRC and fold byte in
      OP_ACC,     // fold byte into CRC
      OP_LOW,     // low byte of received CRC
      OP_CHECK,   // high byte of received CRC: compare, close frame
      OP_ABORT    // unknown function code: close frame
   } op_type;

   typedef struct packed {
      logic [7:0] data;
      logic [8:0] index;
      op_type     op;
   } entry_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/rtu_response_deframer_crc16.sv
// Response deframer with CRC-16 check: one received byte per transfer.
// An accepted byte is written into the queue, then into the back-end output register that drives rsp_.
// Throughput: one byte per cycle, sustained; the front end keeps taking bytes
// while a result waits, until the four-entry queue between front and back fills.
// Reset (synchronous, active high): hunt for address, CRC at 0xFFFF, queue empty,
// device_address back to 1.
module rtu_response_deframer_crc16
   import rrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // received bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // frame bytes out
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic [8:0] rsp_byte_index,
   output logic       rsp_last,
   output logic [1:0] rsp_status,
   // device address register
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_device_address
);

   logic       [7:0] device_address_ff;
   logic       [7:0] device_address_in;
   logic             push;
   entry_type        push_entry;
   logic             queue_full;
   logic             pop;
   entry_type        pop_entry;
   logic             queue_not_empty;

   // Register writes are always taken; the user must write only while the block is idle
   // (the block itself does not enforce this), so the new address applies from the next hunt.
   assign csr_ready         = 1'b1;
   assign device_address_in = (csr_valid && csr_ready) ? csr_device_address
                                                       : device_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 8'd1;
      end else begin
         device_address_ff <= device_address_in;
      end
   end

   // Front: classify bytes, track position and frame length, tag each byte.
   rrd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (req_valid),
      .byte_data      (req_rx_byte),
      .queue_full     (queue_full),
      .device_address (device_address_ff),
      .byte_stall     (req_stall),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Queue: lets each side stall on its own.
   rrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (queue_not_empty)
   );

   // Back: CRC accumulate and check, output register.
   rrd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .not_empty      (queue_not_empty),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_frame_byte (rsp_frame_byte),
      .out_byte_index (rsp_byte_index),
      .out_last       (rsp_last),
      .out_status     (rsp_status)
   );

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall == queue_full)
      else $error("input stall disagrees with queue state");

   a_first_out_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && rsp_status == STATUS_UNKNOWN) |-> (rsp_byte_index == 9'd1))
      else $error("unknown function reported away from index one");

   a_result_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !queue_not_empty) |=> !rsp_valid)
      else $error("result without queued byte");

endmodule

>>> rtl/core/rrd_front.sv
// Front end of the deframer: hunts for the address, decodes the function code,
// tracks frame position and tags each frame byte with its back-end operation.
// Depends on rrd_pkg.
module rrd_front
   import rrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   input  logic       queue_full,
   input  logic [7:0] device_address,
   output logic       byte_stall,
   output logic       push,
   output entry_type  push_entry
);

   phase_type  phase_ff, phase_in;
   logic [8:0] position_ff, position_in;
   logic [8:0] exp_len_ff, exp_len_in;
   logic       take;
   logic [9:0] pos_plus2;
   logic       is_exception;

   assign byte_stall   = queue_full;
   assign take         = byte_valid && !queue_full;
   assign pos_plus2    = {1'b0, position_ff} + 10'd2;
   assign is_exception = (byte_data & FUNC_MASK) == FUNC_EXCEPTION;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (byte_data == device_address) phase_in = PH_FUNC;
            end
            PH_FUNC: begin
               if (is_exception || byte_data == FUNC_COILS || byte_data == FUNC_INPUTS) begin
                  phase_in = PH_BODY;
               end else if (byte_data == FUNC_HOLDING) begin
                  phase_in = PH_COUNT;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_COUNT: phase_in = PH_BODY;
            PH_BODY: begin
               if (pos_plus2 > {1'b0, exp_len_ff}) phase_in = PH_HUNT;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // outputs and datapath registers
   always_comb begin
      push             = 1'b0;
      push_entry.data  = byte_data;
      push_entry.index = position_ff;
      push_entry.op    = OP_ACC;
      position_in      = position_ff;
      exp_len_in       = exp_len_ff;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (byte_data == device_address) begin
                  push             = 1'b1;
                  push_entry.index = 9'd0;
                  push_entry.op    = OP_START;
                  position_in      = 9'd1;
               end
            end
            PH_FUNC: begin
               push             = 1'b1;
               push_entry.index = 9'd1;
               position_in      = 9'd2;
               if (is_exception) begin
                  exp_len_in = LEN_EXCEPTION;
               end else if (byte_data == FUNC_COILS) begin
                  exp_len_in = LEN_COILS;
               end else if (byte_data == FUNC_INPUTS) begin
                  exp_len_in = LEN_INPUTS;
               end else if (byte_data != FUNC_HOLDING) begin
                  push_entry.op = OP_ABORT;
                  position_in   = 9'd0;
                  exp_len_in    = 9'd0;
               end
            end
            PH_COUNT: begin
               push             = 1'b1;
               push_entry.index = 9'd2;
               position_in      = 9'd3;
               exp_len_in       = {1'b0, byte_data} + LEN_OVERHEAD;
            end
            PH_BODY: begin
               push = 1'b1;
               if (pos_plus2 < {1'b0, exp_len_ff}) begin
                  position_in = position_ff + 9'd1;
               end else if (pos_plus2 == {1'b0, exp_len_ff}) begin
                  push_entry.op = OP_LOW;
                  position_in   = position_ff + 9'd1;
               end else begin
                  push_entry.op = OP_CHECK;
                  position_in   = 9'd0;
                  exp_len_in    = 9'd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         position_ff <= 9'd0;
         exp_len_ff  <= 9'd0;
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         exp_len_ff  <= exp_len_in;
      end
   end

   a_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      push |-> ((push_entry.op == OP_START) == (push_entry.index == 9'd0)))
      else $error("frame start not tagged at index zero");

   a_hunt_position: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (position_ff == 9'd0))
      else $error("position nonzero while hunting");

endmodule

>>> rtl/core/rrd_queue.sv
// Small register FIFO that decouples the front end from the back end.
// Depends on rrd_pkg.
module rrd_queue
   import rrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      not_empty
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

>>> rtl/core/rrd_back.sv
// Back end of the deframer: runs the CRC over queued bytes, checks the received
// CRC at frame end and holds the result in an output register. Depends on rrd_pkg.
module rrd_back
   import rrd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       not_empty,
   input  entry_type  pop_entry,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_stall,
   output logic [7:0] out_frame_byte,
   output logic [8:0] out_byte_index,
   output logic       out_last,
   output logic [1:0] out_status
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [8:0]  index_ff, index_in;
   logic        last_ff, last_in;
   logic [1:0]  status_ff, status_in;

   // advance when the output register is empty or being drained
   assign pop = not_empty && (!valid_ff || !out_stall);

   always_comb begin
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      valid_in   = valid_ff && out_stall;
      byte_in    = byte_ff;
      index_in   = index_ff;
      last_in    = last_ff;
      status_in  = status_ff;
      if (pop) begin
         valid_in  = 1'b1;
         byte_in   = pop_entry.data;
         index_in  = pop_entry.index;
         last_in   = 1'b0;
         status_in = STATUS_OK;
         case (pop_entry.op)
            OP_START: crc_in = crc16_update(CRC_INIT, pop_entry.data);
            OP_ACC:   crc_in = crc16_update(crc_ff, pop_entry.data);
            OP_LOW:   crc_low_in = pop_entry.data;
            OP_CHECK: begin
               last_in   = 1'b1;
               status_in = ({pop_entry.data, crc_low_ff} == crc_ff) ?
                           STATUS_OK : STATUS_CRC_ERR;
            end
            OP_ABORT: begin
               last_in   = 1'b1;
               status_in = STATUS_UNKNOWN;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= 8'd0;
      end else begin
         valid_ff   <= valid_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      index_ff  <= index_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign out_valid      = valid_ff;
   assign out_frame_byte = byte_ff;
   assign out_byte_index = index_ff;
   assign out_last       = last_ff;
   assign out_status     = status_ff;

   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> (status_ff == STATUS_OK))
      else $error("nonzero status on non-final byte");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (status_ff != 2'd3))
      else $error("status code out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_stall) |=> (valid_ff && $stable(index_ff)))
      else $error("result dropped under stall");

endmodule
